### src/vts_pkg.sv
// vts_pkg: shared constants and types of the voxel trilinear sampler
// no dependencies; imported by vts_front, vts_back and voxel_trilinear_sampler

`default_nettype none

package vts_pkg;

   // grid and number formats
   localparam int MAX_DIM         = 32;
   localparam int VALUE_BITS      = 16;
   localparam int COORD_FRAC_BITS = 16;
   localparam int COORD_W         = 16;
   localparam int IN_ADDR_W       = 15;
   localparam int SIZE_W          = 6;
   localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(32);

   // request function codes
   localparam logic FUNC_WRITE  = 1'b0;
   localparam logic FUNC_SAMPLE = 1'b1;

   // register indexes
   localparam logic [1:0] REG_SIZE_X = 2'd0;
   localparam logic [1:0] REG_SIZE_Y = 2'd1;
   localparam logic [1:0] REG_SIZE_Z = 2'd2;

   // derived widths
   localparam int IDX_W       = $clog2(MAX_DIM);
   localparam int DIM_W       = $clog2(MAX_DIM + 1);
   localparam int ROW_W       = $clog2(MAX_DIM * MAX_DIM);
   localparam int STORE_DEPTH = MAX_DIM * MAX_DIM * MAX_DIM;
   localparam int ADDR_W      = $clog2(STORE_DEPTH);

   // register port
   localparam int CSR_AW = 4;
   localparam int CSR_DW = 32;

   // axis sizes as held in the registers
   typedef struct packed {
      logic [SIZE_W-1:0] size_x;
      logic [SIZE_W-1:0] size_y;
      logic [SIZE_W-1:0] size_z;
   } size_cfg_type;

   // one classified request passed from the front end to the back end
   typedef struct packed {
      logic                                sample;
      logic                                wr_en;
      logic [ADDR_W-1:0]                   wr_addr;
      logic [VALUE_BITS-1:0]               wr_value;
      logic [3:0][ADDR_W-1:0]              base;
      logic [1:0][IDX_W-1:0]               zi;
      logic [COORD_FRAC_BITS-1:0]          fx;
      logic [COORD_FRAC_BITS-1:0]          fy;
      logic [COORD_FRAC_BITS-1:0]          fz;
   } job_type;

endpackage

`default_nettype wire

### src/vts_queue.sv
// vts_queue: small register queue with full and empty flags
// no dependencies; used between front and back end and on the result side

`default_nettype none

module vts_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wdata,
   output logic             full,
   input  logic             pop,
   output logic             empty,
   output logic [WIDTH-1:0] rdata
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rdata   = slot_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // slot storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

`default_nettype wire

### src/vts_front.sv
// vts_front: accepts requests, splits sample points into cells and fractions
// and works out the four corner row addresses; depends on vts_pkg

`default_nettype none

module vts_front (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            push,
   output logic                            full,
   input  logic                            req_func,
   input  logic [vts_pkg::IN_ADDR_W-1:0]   req_voxel_address,
   input  logic [vts_pkg::VALUE_BITS-1:0]  req_voxel_value,
   input  logic [vts_pkg::COORD_W-1:0]     req_point_x,
   input  logic [vts_pkg::COORD_W-1:0]     req_point_y,
   input  logic [vts_pkg::COORD_W-1:0]     req_point_z,
   input  vts_pkg::size_cfg_type           cfg,
   output logic                            job_push,
   input  logic                            job_full,
   output vts_pkg::job_type                job
);

   import vts_pkg::*;

   localparam int   SCL_W       = COORD_FRAC_BITS + DIM_W;

   localparam logic [2:0] F_IDLE  = 3'd0;
   localparam logic [2:0] F_SCALE = 3'd1;
   localparam logic [2:0] F_ROW   = 3'd2;
   localparam logic [2:0] F_BASE  = 3'd3;
   localparam logic [2:0] F_PUSH  = 3'd4;

   typedef struct packed {
      logic [IDX_W-1:0]           lo;
      logic [IDX_W-1:0]           hi;
      logic [COORD_FRAC_BITS-1:0] frac;
   } axis_type;

   // size register saturated to the usable range
   function automatic logic [DIM_W-1:0] eff_size(input logic [SIZE_W-1:0] s);
      logic [DIM_W-1:0] r;
      if (32'(s) < 2) begin
         r = DIM_W'(2);
      end else if (32'(s) > MAX_DIM) begin
         r = DIM_W'(MAX_DIM);
      end else begin
         r = DIM_W'(s);
      end
      return r;
   endfunction

   // coordinate to lower index, upper index and fraction
   function automatic axis_type split(input logic [COORD_W-1:0] p,
                                      input logic [DIM_W-1:0] n);
      logic [COORD_FRAC_BITS-1:0] c;
      logic [SCL_W-1:0]           s;
      logic [DIM_W-1:0]           cell_idx;
      logic [DIM_W-1:0]           last;
      axis_type                   a;
      c    = p[COORD_FRAC_BITS-1:0];
      if (c == '0) begin
         c = COORD_FRAC_BITS'(1);
      end
      s    = SCL_W'(c) * SCL_W'(n);
      last = n - DIM_W'(1);
      cell_idx = s[COORD_FRAC_BITS +: DIM_W];
      if (cell_idx > last) begin
         cell_idx = last;
      end
      a.lo   = cell_idx[IDX_W-1:0];
      a.hi   = (cell_idx >= last) ? last[IDX_W-1:0] : IDX_W'(cell_idx + DIM_W'(1));
      a.frac = s[COORD_FRAC_BITS-1:0];
      return a;
   endfunction

   logic [2:0]         state_ff, state_in;
   logic [COORD_W-1:0] pt_x_ff, pt_x_in;
   logic [COORD_W-1:0] pt_y_ff, pt_y_in;
   logic [COORD_W-1:0] pt_z_ff, pt_z_in;
   axis_type           ax_x_ff, ax_x_in;
   axis_type           ax_y_ff, ax_y_in;
   logic [ROW_W-1:0]   row_ff [4];
   logic [ROW_W-1:0]   row_in [4];
   job_type            job_ff, job_in;
   logic [DIM_W-1:0]   nx, ny, nz;

   assign nx       = eff_size(cfg.size_x);
   assign ny       = eff_size(cfg.size_y);
   assign nz       = eff_size(cfg.size_z);
   assign full     = (state_ff != F_IDLE);
   assign job      = job_ff;
   assign job_push = (state_ff == F_PUSH);

   // request sequencer
   always_comb begin
      axis_type         ax_z;
      logic [ROW_W-1:0] xe;
      logic [ROW_W-1:0] ye;
      logic [ROW_W-1:0] ne;
      state_in = state_ff;
      pt_x_in  = pt_x_ff;
      pt_y_in  = pt_y_ff;
      pt_z_in  = pt_z_ff;
      ax_x_in  = ax_x_ff;
      ax_y_in  = ax_y_ff;
      row_in   = row_ff;
      job_in   = job_ff;
      ax_z     = split(pt_z_ff, nz);
      xe       = '0;
      ye       = '0;
      ne       = ROW_W'(ny);
      case (state_ff)
         F_IDLE: begin
            if (push) begin
               if (req_func == FUNC_SAMPLE) begin
                  pt_x_in  = req_point_x;
                  pt_y_in  = req_point_y;
                  pt_z_in  = req_point_z;
                  state_in = F_SCALE;
               end else begin
                  job_in.sample   = 1'b0;
                  job_in.wr_en    = (32'(req_voxel_address) < STORE_DEPTH);
                  job_in.wr_addr  = ADDR_W'(req_voxel_address);
                  job_in.wr_value = req_voxel_value;
                  state_in        = F_PUSH;
               end
            end
         end
         F_SCALE: begin
            ax_x_in         = split(pt_x_ff, nx);
            ax_y_in         = split(pt_y_ff, ny);
            job_in.sample   = 1'b1;
            job_in.wr_en    = 1'b0;
            job_in.wr_addr  = '0;
            job_in.wr_value = '0;
            job_in.zi[0]    = ax_z.lo;
            job_in.zi[1]    = ax_z.hi;
            job_in.fz       = ax_z.frac;
            job_in.fx       = ax_x_in.frac;
            job_in.fy       = ax_y_in.frac;
            state_in        = F_ROW;
         end
         F_ROW: begin
            // row of corner {i,j} is x_i * ny + y_j
            for (int k = 0; k < 4; k++) begin
               xe = ROW_W'(((k & 2) != 0) ? ax_x_ff.hi : ax_x_ff.lo);
               ye = ROW_W'(((k & 1) != 0) ? ax_y_ff.hi : ax_y_ff.lo);
               row_in[k] = xe * ne + ye;
            end
            state_in = F_BASE;
         end
         F_BASE: begin
            for (int k = 0; k < 4; k++) begin
               job_in.base[k] = ADDR_W'(row_ff[k]) * ADDR_W'(nz);
            end
            state_in = F_PUSH;
         end
         F_PUSH: begin
            if (!job_full) begin
               state_in = F_IDLE;
            end
         end
         default: begin
            state_in = F_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // request payload and intermediate results
   always_ff @(posedge clock) begin
      pt_x_ff <= pt_x_in;
      pt_y_ff <= pt_y_in;
      pt_z_ff <= pt_z_in;
      ax_x_ff <= ax_x_in;
      ax_y_ff <= ax_y_in;
      row_ff  <= row_in;
      job_ff  <= job_in;
   end

endmodule

`default_nettype wire

### src/vts_back.sv
// vts_back: voxel memory, eight corner reads and the z, y, x blend chain
// depends on vts_pkg; takes jobs from the front queue, pushes results

`default_nettype none

module vts_back (
   input  logic                           clock,
   input  logic                           reset,
   input  vts_pkg::job_type               job,
   input  logic                           job_empty,
   output logic                           job_pop,
   output logic                           out_push,
   output logic [vts_pkg::VALUE_BITS-1:0] out_data,
   input  logic                           out_full
);

   import vts_pkg::*;

   localparam int ACC_W  = VALUE_BITS + COORD_FRAC_BITS + 2;
   localparam int STEP_W = 4;

   localparam logic [STEP_W-1:0] STEP_LAST_READ = STEP_W'(7);
   localparam logic [STEP_W-1:0] STEP_PLANE_0   = STEP_W'(5);
   localparam logic [STEP_W-1:0] STEP_PLANE_1   = STEP_W'(9);
   localparam logic [STEP_W-1:0] STEP_DONE      = STEP_W'(10);

   // a + (b - a) * f / 2^F, rounded to nearest with ties upward
   function automatic logic [VALUE_BITS-1:0] lerp(input logic [VALUE_BITS-1:0] a,
                                                  input logic [VALUE_BITS-1:0] b,
                                                  input logic [COORD_FRAC_BITS-1:0] f);
      logic signed [VALUE_BITS:0] d;
      logic signed [ACC_W-1:0]    base_t;
      logic signed [ACC_W-1:0]    prod;
      logic signed [ACC_W-1:0]    acc;
      d      = signed'({1'b0, b}) - signed'({1'b0, a});
      base_t = signed'({2'b00, a, {COORD_FRAC_BITS{1'b0}}});
      prod   = d * signed'({1'b0, f});
      acc    = base_t + prod
               + signed'({{(ACC_W - COORD_FRAC_BITS){1'b0}}, 1'b1,
                          {(COORD_FRAC_BITS - 1){1'b0}}});
      return acc[COORD_FRAC_BITS +: VALUE_BITS];
   endfunction

   logic [VALUE_BITS-1:0] mem [STORE_DEPTH];
   logic [VALUE_BITS-1:0] rdata_ff;

   logic                  busy_ff, busy_in;
   logic [STEP_W-1:0]     step_ff, step_in;
   job_type               job_ff, job_in;
   logic [VALUE_BITS-1:0] lo_ff, lo_in;
   logic [VALUE_BITS-1:0] line_ff [4];
   logic [VALUE_BITS-1:0] line_in [4];
   logic [VALUE_BITS-1:0] plane_ff [2];
   logic [VALUE_BITS-1:0] plane_in [2];

   logic                  mem_we, mem_re;
   logic [ADDR_W-1:0]     mem_addr;
   logic [2:0]            line_half;
   logic [1:0]            line_sel;

   assign line_half = step_ff[3:1] - 3'd1;
   assign line_sel  = line_half[1:0];
   assign job_pop   = !busy_ff && !job_empty;
   assign out_push  = busy_ff && (step_ff == STEP_DONE);
   assign out_data  = lerp(plane_ff[0], plane_ff[1], job_ff.fx);

   // memory port: writes from idle, corner reads from the sample sequence
   always_comb begin
      mem_we   = job_pop && !job.sample && job.wr_en;
      mem_re   = busy_ff && (step_ff <= STEP_LAST_READ);
      mem_addr = job.wr_addr;
      if (busy_ff) begin
         mem_addr = job_ff.base[step_ff[2:1]] + ADDR_W'(job_ff.zi[step_ff[0]]);
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_addr] <= job.wr_value;
      end
      if (mem_re) begin
         rdata_ff <= mem[mem_addr];
      end
   end

   // sample sequencer and blend chain
   always_comb begin
      busy_in  = busy_ff;
      step_in  = step_ff;
      job_in   = job_ff;
      lo_in    = lo_ff;
      line_in  = line_ff;
      plane_in = plane_ff;
      if (!busy_ff) begin
         if (job_pop && job.sample) begin
            job_in  = job;
            busy_in = 1'b1;
            step_in = '0;
         end
      end else begin
         // even corner waits for its partner along z
         if (step_ff[0] && (step_ff <= STEP_LAST_READ)) begin
            lo_in = rdata_ff;
         end
         // z blend when the odd corner arrives
         if (!step_ff[0] && (step_ff >= STEP_W'(2)) && (step_ff <= STEP_W'(8))) begin
            line_in[line_sel] = lerp(lo_ff, rdata_ff, job_ff.fz);
         end
         // y blends once both lines of a plane are ready
         if (step_ff == STEP_PLANE_0) begin
            plane_in[0] = lerp(line_ff[0], line_ff[1], job_ff.fy);
         end
         if (step_ff == STEP_PLANE_1) begin
            plane_in[1] = lerp(line_ff[2], line_ff[3], job_ff.fy);
         end
         if (step_ff == STEP_DONE) begin
            if (!out_full) begin
               busy_in = 1'b0;
            end
         end else begin
            step_in = step_ff + STEP_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff   <= job_in;
      lo_ff    <= lo_in;
      line_ff  <= line_in;
      plane_ff <= plane_in;
   end

   // single port: never a write and a read together
   a_port_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(mem_we && mem_re))
      else $error("voxel memory written and read in the same cycle");

   // the sequence never runs past its last step
   a_step_bound: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (step_ff <= STEP_DONE))
      else $error("sample sequence step out of range");

   // a delivered result frees the back end
   a_done_frees: assert property (@(posedge clock) disable iff (reset)
      (out_push && !out_full) |=> !busy_ff)
      else $error("back end still busy after delivering a result");

endmodule

`default_nettype wire

### src/voxel_trilinear_sampler.sv
// voxel_trilinear_sampler: top level with size registers, front end, job queue,
// back end and result queue; depends on vts_pkg, vts_front, vts_queue, vts_back
//
//   channel    handshake               payload
//   request    push / full             req_func, req_voxel_address, req_voxel_value,
//                                      req_point_x, req_point_y, req_point_z
//   result     empty / pop             rsp_density
//   registers  psel/penable/pwrite     paddr, pwdata, prdata (size_x, size_y, size_z)
//
// A write request goes from idle straight to push in the front end; the back end writes
// it to the voxel memory as it pops it. A sample request passes the front-end states
// idle, scale, row, base and push; the back end pops no new job until its eight corner
// reads through the single voxel memory port and the z, y, x blend chain are done.
// Reset clears control state and sets all sizes to 32; the voxel memory is not
// cleared and an unwritten voxel reads as an undefined value.
// A two-entry job queue parts the front and back ends, and a two-entry result
// queue lets the back end finish while a result waits to be popped.

`default_nettype none

module voxel_trilinear_sampler (
   input  logic                           clock,
   input  logic                           reset,
   // requests
   input  logic                           push,
   output logic                           full,
   input  logic                           req_func,
   input  logic [vts_pkg::IN_ADDR_W-1:0]  req_voxel_address,
   input  logic [vts_pkg::VALUE_BITS-1:0] req_voxel_value,
   input  logic [vts_pkg::COORD_W-1:0]    req_point_x,
   input  logic [vts_pkg::COORD_W-1:0]    req_point_y,
   input  logic [vts_pkg::COORD_W-1:0]    req_point_z,
   // results
   output logic                           empty,
   input  logic                           pop,
   output logic [vts_pkg::VALUE_BITS-1:0] rsp_density,
   // registers
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [vts_pkg::CSR_AW-1:0]     paddr,
   input  logic [vts_pkg::CSR_DW-1:0]     pwdata,
   output logic [vts_pkg::CSR_DW-1:0]     prdata,
   output logic                           pready
);

   import vts_pkg::*;

   localparam int JOB_W       = $bits(job_type);
   localparam int QUEUE_DEPTH = 2;

   logic [SIZE_W-1:0] size_x_ff, size_x_in;
   logic [SIZE_W-1:0] size_y_ff, size_y_in;
   logic [SIZE_W-1:0] size_z_ff, size_z_in;
   size_cfg_type      cfg;
   logic              csr_wr;
   logic [1:0]        csr_idx;

   job_type               front_job;
   logic                  front_push;
   logic                  jq_full;
   logic                  jq_empty;
   logic                  jq_pop;
   logic [JOB_W-1:0]      jq_rdata;
   logic                  out_push;
   logic                  out_full;
   logic [VALUE_BITS-1:0] out_data;

   // size registers
   assign pready  = 1'b1;
   assign csr_wr  = psel && penable && pwrite;
   assign csr_idx = paddr[3:2];

   always_comb begin
      size_x_in = size_x_ff;
      size_y_in = size_y_ff;
      size_z_in = size_z_ff;
      if (csr_wr) begin
         case (csr_idx)
            REG_SIZE_X: size_x_in = pwdata[SIZE_W-1:0];
            REG_SIZE_Y: size_y_in = pwdata[SIZE_W-1:0];
            REG_SIZE_Z: size_z_in = pwdata[SIZE_W-1:0];
            default:    size_x_in = size_x_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         size_x_ff <= SIZE_RESET;
         size_y_ff <= SIZE_RESET;
         size_z_ff <= SIZE_RESET;
      end else begin
         size_x_ff <= size_x_in;
         size_y_ff <= size_y_in;
         size_z_ff <= size_z_in;
      end
   end

   // register read back
   always_comb begin
      case (csr_idx)
         REG_SIZE_X: prdata = CSR_DW'(size_x_ff);
         REG_SIZE_Y: prdata = CSR_DW'(size_y_ff);
         REG_SIZE_Z: prdata = CSR_DW'(size_z_ff);
         default:    prdata = '0;
      endcase
   end

   assign cfg.size_x = size_x_ff;
   assign cfg.size_y = size_y_ff;
   assign cfg.size_z = size_z_ff;

   // request classification and address set-up
   vts_front u_front (
      .clock             (clock),
      .reset             (reset),
      .push              (push),
      .full              (full),
      .req_func          (req_func),
      .req_voxel_address (req_voxel_address),
      .req_voxel_value   (req_voxel_value),
      .req_point_x       (req_point_x),
      .req_point_y       (req_point_y),
      .req_point_z       (req_point_z),
      .cfg               (cfg),
      .job_push          (front_push),
      .job_full          (jq_full),
      .job               (front_job)
   );

   // job queue between the two ends
   vts_queue #(
      .WIDTH (JOB_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_job_queue (
      .clock (clock),
      .reset (reset),
      .push  (front_push),
      .wdata (front_job),
      .full  (jq_full),
      .pop   (jq_pop),
      .empty (jq_empty),
      .rdata (jq_rdata)
   );

   // voxel memory and interpolation
   vts_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job       (job_type'(jq_rdata)),
      .job_empty (jq_empty),
      .job_pop   (jq_pop),
      .out_push  (out_push),
      .out_data  (out_data),
      .out_full  (out_full)
   );

   // result queue
   vts_queue #(
      .WIDTH (VALUE_BITS),
      .DEPTH (QUEUE_DEPTH)
   ) u_rsp_queue (
      .clock (clock),
      .reset (reset),
      .push  (out_push),
      .wdata (out_data),
      .full  (out_full),
      .pop   (pop),
      .empty (empty),
      .rdata (rsp_density)
   );

endmodule

`default_nettype wire

### test/tb.sv
// tb: self-checking testbench for voxel_trilinear_sampler, with its own density predictor
// depends on vts_pkg and the voxel_trilinear_sampler rtl; no files or arguments are read
`timescale 1ns / 1ps

module tb;
   import vts_pkg::*;

   // register list bounds
   localparam int REG_SPARE  = 3;
   localparam int REG_COUNT  = 3;
   localparam int SETTLE_CYCLES = 40;

   typedef struct {
      logic                   func;
      logic [IN_ADDR_W-1:0]   voxel_address;
      logic [VALUE_BITS-1:0]  voxel_value;
      logic [COORD_W-1:0]     point_x;
      logic [COORD_W-1:0]     point_y;
      logic [COORD_W-1:0]     point_z;
   } voxel_request_type;

   // block ports
   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  push = 1'b0;
   logic                  full;
   logic                  req_func = FUNC_WRITE;
   logic [IN_ADDR_W-1:0]  req_voxel_address = '0;
   logic [VALUE_BITS-1:0] req_voxel_value = '0;
   logic [COORD_W-1:0]    req_point_x = '0;
   logic [COORD_W-1:0]    req_point_y = '0;
   logic [COORD_W-1:0]    req_point_z = '0;
   logic                  empty;
   logic                  pop = 1'b0;
   logic [VALUE_BITS-1:0] rsp_density;
   logic                  psel = 1'b0;
   logic                  penable = 1'b0;
   logic                  pwrite = 1'b0;
   logic [CSR_AW-1:0]     paddr = '0;
   logic [CSR_DW-1:0]     pwdata = '0;
   logic [CSR_DW-1:0]     prdata;
   logic                  pready;

   // predictor state
   logic [VALUE_BITS-1:0] voxel_model [STORE_DEPTH];
   bit                    voxel_written [STORE_DEPTH];
   logic [SIZE_W-1:0]     size_reg [REG_COUNT] = '{SIZE_RESET, SIZE_RESET, SIZE_RESET};
   logic [VALUE_BITS-1:0] density_expected [$];

   int error_count   = 0;
   int sent_count    = 0;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;

   voxel_trilinear_sampler u_dut (
      .clock             (clock),
      .reset             (reset),
      .push              (push),
      .full              (full),
      .req_func          (req_func),
      .req_voxel_address (req_voxel_address),
      .req_voxel_value   (req_voxel_value),
      .req_point_x       (req_point_x),
      .req_point_y       (req_point_y),
      .req_point_z       (req_point_z),
      .empty             (empty),
      .pop               (pop),
      .rsp_density       (rsp_density),
      .psel              (psel),
      .penable           (penable),
      .pwrite            (pwrite),
      .paddr             (paddr),
      .pwdata            (pwdata),
      .prdata            (prdata),
      .pready            (pready)
   );

   // clock
   initial begin
      forever #10 clock = ~clock;
   end

   // run limit
   initial begin
      #10_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   task automatic note_error(input string what, input logic [31:0] expected,
                             input logic [31:0] actual);
      error_count++;
      if (error_count <= 10)
         $display("mismatch in %s: expected %h, got %h at %0t", what, expected, actual, $time);
   endtask

   // ---------------------------------------------------------------- predictor

   // a size register out of range is saturated into 2..MAX_DIM
   function automatic int unsigned axis_size(input logic [SIZE_W-1:0] s);
      if (s < 2) return 2;
      if (s > MAX_DIM) return MAX_DIM;
      return s;
   endfunction

   // coordinate to lower index, upper index and fraction; zero is raised to one lsb
   function automatic void split_axis(input logic [COORD_W-1:0] raw, input int unsigned n,
                                      output int unsigned lo, output int unsigned hi,
                                      output longint unsigned frac);
      longint unsigned c;
      longint unsigned scaled;
      c = raw;
      if (c == 0) c = 1;
      scaled = c * n;
      lo = int'(scaled >> COORD_FRAC_BITS);
      if (lo > n - 1) lo = n - 1;
      hi = (lo + 1 > n - 1) ? n - 1 : lo + 1;
      frac = scaled & ((64'd1 << COORD_FRAC_BITS) - 1);
   endfunction

   // corner k has x upper in bit 2, y upper in bit 1, z upper in bit 0
   function automatic void locate_cell(input voxel_request_type r, output int unsigned addr[8],
                                       output longint unsigned frac[3]);
      int unsigned n [3];
      int unsigned lo [3];
      int unsigned hi [3];
      logic [COORD_W-1:0] pt [3];
      int unsigned xi, yi, zi;
      int a, k;
      pt = '{r.point_x, r.point_y, r.point_z};
      for (a = 0; a < 3; a++) begin
         n[a] = axis_size(size_reg[a]);
         split_axis(pt[a], n[a], lo[a], hi[a], frac[a]);
      end
      for (k = 0; k < 8; k++) begin
         xi = (k & 4) ? hi[0] : lo[0];
         yi = (k & 2) ? hi[1] : lo[1];
         zi = (k & 1) ? hi[2] : lo[2];
         addr[k] = (xi * n[1] + yi) * n[2] + zi;
      end
   endfunction

   // weighted blend of two values, rounded to nearest with ties upward
   function automatic logic [VALUE_BITS-1:0] blend(input logic [VALUE_BITS-1:0] a,
                                                   input logic [VALUE_BITS-1:0] b,
                                                   input longint unsigned f);
      longint unsigned wa;
      longint unsigned wb;
      longint unsigned acc;
      wa = a;
      wb = b;
      acc = wa * ((64'd1 << COORD_FRAC_BITS) - f) + wb * f + (64'd1 << (COORD_FRAC_BITS - 1));
      return VALUE_BITS'(acc >> COORD_FRAC_BITS);
   endfunction

   // blend along z, then y, then x
   function automatic logic [VALUE_BITS-1:0] predict_density(input voxel_request_type r);
      int unsigned addr [8];
      longint unsigned frac [3];
      logic [VALUE_BITS-1:0] line_val [4];
      logic [VALUE_BITS-1:0] plane_val [2];
      int k;
      locate_cell(r, addr, frac);
      for (k = 0; k < 4; k++)
         line_val[k] = blend(voxel_model[addr[2*k]], voxel_model[addr[2*k+1]], frac[2]);
      for (k = 0; k < 2; k++)
         plane_val[k] = blend(line_val[2*k], line_val[2*k+1], frac[1]);
      return blend(plane_val[0], plane_val[1], frac[0]);
   endfunction

   // ---------------------------------------------------------------- stimulus helpers

   // unused fields of a request carry random noise
   function automatic voxel_request_type make_write(input logic [IN_ADDR_W-1:0] addr,
                                                    input logic [VALUE_BITS-1:0] value);
      voxel_request_type r;
      r.func = FUNC_WRITE;
      r.voxel_address = addr;
      r.voxel_value = value;
      r.point_x = $urandom;
      r.point_y = $urandom;
      r.point_z = $urandom;
      return r;
   endfunction

   function automatic voxel_request_type make_sample(input logic [COORD_W-1:0] px,
                                                     input logic [COORD_W-1:0] py,
                                                     input logic [COORD_W-1:0] pz);
      voxel_request_type r;
      r.func = FUNC_SAMPLE;
      r.voxel_address = $urandom;
      r.voxel_value = $urandom;
      r.point_x = px;
      r.point_y = py;
      r.point_z = pz;
      return r;
   endfunction

   // coordinates lean toward the edges and the middle of the unit cube now and then
   function automatic logic [COORD_W-1:0] random_coord();
      case ($urandom_range(19))
         0: return '0;
         1: return 1;
         2: return '1;
         3: return {1'b1, {(COORD_W-1){1'b0}}};
         default: return $urandom;
      endcase
   endfunction

   // one request; starts and ends on a rising edge, push left high after acceptance
   task automatic send_request(input voxel_request_type r);
      while ($urandom_range(99) < send_idle_pct) begin
         push <= 1'b0;
         @(posedge clock);
      end
      push <= 1'b1;
      req_func <= r.func;
      req_voxel_address <= r.voxel_address;
      req_voxel_value <= r.voxel_value;
      req_point_x <= r.point_x;
      req_point_y <= r.point_y;
      req_point_z <= r.point_z;
      do @(posedge clock); while (full);
      sent_count++;
      if (r.func == FUNC_WRITE) begin
         voxel_model[r.voxel_address] = r.voxel_value;
         voxel_written[r.voxel_address] = 1'b1;
      end else begin
         density_expected.push_back(predict_density(r));
      end
   endtask

   // a sample whose corners are loaded first where they have never been written
   task automatic sample_point(input logic [COORD_W-1:0] px, input logic [COORD_W-1:0] py,
                               input logic [COORD_W-1:0] pz);
      voxel_request_type r;
      int unsigned addr [8];
      longint unsigned frac [3];
      int k;
      r = make_sample(px, py, pz);
      locate_cell(r, addr, frac);
      for (k = 0; k < 8; k++)
         if (!voxel_written[addr[k]])
            send_request(make_write(IN_ADDR_W'(addr[k]), VALUE_BITS'($urandom)));
      send_request(r);
   endtask

   // stop requests and wait for every outstanding density
   task automatic await_results(input int extra_cycles);
      push <= 1'b0;
      @(posedge clock);
      while (density_expected.size() != 0) @(posedge clock);
      repeat (extra_cycles) @(posedge clock);
   endtask

   task automatic csr_write(input int index, input logic [CSR_DW-1:0] data);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= CSR_AW'(index * 4);
      pwdata <= data;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (index < REG_COUNT) size_reg[index] = data[SIZE_W-1:0];
      psel <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic csr_read(input int index, output logic [CSR_DW-1:0] data);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= CSR_AW'(index * 4);
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      data = prdata;
      psel <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   // ---------------------------------------------------------------- tests

   // one sample at the reset sizes, upper x corner clamped
   task automatic test_reset_size_sample();
      sample_point(16'hFFFF, 16'h0000, 16'h8000);
   endtask

   // size writes with random upper bits, a write past the register list, read back
   task automatic test_size_registers(input logic [SIZE_W-1:0] sx, input logic [SIZE_W-1:0] sy,
                                      input logic [SIZE_W-1:0] sz);
      logic [SIZE_W-1:0] sizes [REG_COUNT];
      logic [CSR_DW-1:0] data;
      int i;
      sizes = '{sx, sy, sz};
      await_results(SETTLE_CYCLES);
      for (i = 0; i < REG_COUNT; i++) begin
         data = $urandom;
         data[SIZE_W-1:0] = sizes[i];
         csr_write(i, data);
      end
      csr_write(REG_SPARE, $urandom);
      for (i = 0; i < REG_COUNT; i++) begin
         csr_read(i, data);
         if (data !== CSR_DW'(size_reg[i])) note_error("size register", size_reg[i], data);
      end
   endtask

   // 2x2x2 grid with extreme values; samples at the cube edges, inside it and behind fresh writes
   task automatic test_small_grid_directed();
      logic [VALUE_BITS-1:0] corner_val [8];
      int k;
      corner_val = '{16'h0000, 16'hFFFF, 16'h1234, 16'hFFFF,
                     16'h0000, 16'h8000, 16'hFFFF, 16'h0001};
      for (k = 0; k < 8; k++)
         send_request(make_write(IN_ADDR_W'(k), corner_val[k]));
      send_request(make_write('1, 16'hA5A5));
      sample_point(16'h0000, 16'h0000, 16'h0000);
      sample_point(16'hFFFF, 16'hFFFF, 16'hFFFF);
      sample_point(16'h8000, 16'h8000, 16'h8000);
      sample_point(16'h4000, 16'hC000, 16'h2000);
      sample_point(16'h0000, 16'hFFFF, 16'h8000);
      sample_point(16'h0001, 16'hFFFE, 16'h7FFF);
      sample_point(16'h5555, 16'hAAAA, 16'h3333);
      send_request(make_write(IN_ADDR_W'(0), 16'hFFFF));
      sample_point(16'h0000, 16'h0000, 16'h0000);
      send_request(make_write(IN_ADDR_W'(7), 16'h0000));
      sample_point(16'hFFFF, 16'hFFFF, 16'hFFFF);
   endtask

   // mix of loads and samples, corner loads included in the request budget;
   // once pause_at requests have gone the sender waits for every density
   task automatic test_random_grid(input int item_count, input int pause_at);
      int unsigned used;
      logic [IN_ADDR_W-1:0] addr;
      logic [VALUE_BITS-1:0] value;
      int start;
      bit paused;
      used = axis_size(size_reg[REG_SIZE_X]) * axis_size(size_reg[REG_SIZE_Y])
             * axis_size(size_reg[REG_SIZE_Z]);
      start = sent_count;
      paused = 1'b0;
      while (sent_count - start < item_count) begin
         if (!paused && (sent_count - start >= pause_at)) begin
            paused = 1'b1;
            await_results(0);
         end
         if ($urandom_range(99) < 35) begin
            if ($urandom_range(1)) addr = IN_ADDR_W'($urandom_range(used - 1));
            else addr = $urandom;
            case ($urandom_range(9))
               0: value = '0;
               1: value = '1;
               default: value = $urandom;
            endcase
            send_request(make_write(addr, value));
         end else begin
            sample_point(random_coord(), random_coord(), random_coord());
         end
      end
   endtask

   // ---------------------------------------------------------------- result checker

   always @(posedge clock) begin
      logic [VALUE_BITS-1:0] want;
      if (!reset && pop && !empty) begin
         if (density_expected.size() == 0) begin
            note_error("unrequested density", '0, rsp_density);
         end else begin
            want = density_expected.pop_front();
            if (rsp_density !== want) note_error("density", want, rsp_density);
         end
      end
      pop <= reset ? 1'b0 : ($urandom_range(99) >= recv_idle_pct);
   end

   // ---------------------------------------------------------------- sequence

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // sender idles less than receiver
      send_idle_pct = 30;
      recv_idle_pct = 58;
      test_reset_size_sample();
      test_size_registers(6'd2, 6'd2, 6'd2);
      test_small_grid_directed();
      test_size_registers(6'd0, 6'd63, 6'd5);
      test_random_grid(300, 150);

      // receiver idles less than sender
      send_idle_pct = 58;
      recv_idle_pct = 30;
      test_size_registers(6'd32, 6'd32, 6'd32);
      test_random_grid(300, 300);
      test_size_registers(6'd1, 6'd7, 6'd33);
      test_random_grid(300, 300);

      // back to back
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_size_registers(SIZE_W'($urandom), SIZE_W'($urandom), SIZE_W'($urandom));
      test_random_grid(300, 300);
      test_size_registers(6'd31, 6'd2, 6'd17);
      test_random_grid(300, 300);

      await_results(SETTLE_CYCLES);
      if (error_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
